/* sv/wbf_pkg.sv */
// Shared types, constants and arithmetic helpers for the WCA boundary force block.
package wbf_pkg;

  // Geometry and pipeline sizing
  localparam int MaxDims      = 3;
  localparam int NumLanes     = 3;
  localparam int SqrtStages   = 16;   // two root bits per stage
  localparam int RinvStages   = 64;   // one quotient bit per stage
  localparam int RatioSteps   = 32;   // ratio divide runs in the first stages
  localparam int TailStages   = 15;
  localparam int NumStages    = 3 + SqrtStages + 2 + RinvStages + TailStages;

  // Context taps in the tail line
  localparam int TcE3 = 10;
  localparam int TcT2 = 12;
  localparam int TcF2 = 14;

  // Register indexes
  typedef enum logic [2:0] {
    REG_DIMS         = 3'd0,
    REG_CONF_RADIUS  = 3'd1,
    REG_CUT_RADIUS   = 3'd2,
    REG_COEF_SIX     = 3'd3,
    REG_COEF_TWELVE  = 3'd4,
    REG_ENERGY_SHIFT = 3'd5,
    REG_FORCE_CAP    = 3'd6
  } reg_idx_t;

  // Reset values
  localparam logic [1:0]  RstDims        = 2'd3;
  localparam logic [30:0] RstConfRadius  = 31'd655360;
  localparam logic [30:0] RstCutRadius   = 31'd73562;
  localparam logic [30:0] RstCoefSix     = 31'd262144;
  localparam logic [30:0] RstCoefTwelve  = 31'd262144;
  localparam logic [30:0] RstEnergyShift = 31'd65536;
  localparam logic [30:0] RstForceCap    = 31'd6553600;

  // Front end context
  typedef struct packed {
    logic [NumLanes-1:0]       pneg;
    logic [NumLanes-1:0][31:0] pmag;
  } front_t;

  // Square root stage
  typedef struct packed {
    logic [63:0] v;
    logic [34:0] rem;
    logic [31:0] root;
    logic        outside;
    front_t      fr;
  } sqp_t;

  // Divider stage
  typedef struct packed {
    logic                      outside;
    logic [NumLanes-1:0]       pneg;
    logic                      dneg;
    logic [31:0]               dmag;
    logic [31:0]               rmag;
    logic [63:0]               d2;
    logic [63:0]               rrem;
    logic [63:0]               rq;
    logic [NumLanes-1:0][31:0] lrem;
    logic [NumLanes-1:0][32:0] lq;
  } dv_t;

  // Tail context
  typedef struct packed {
    logic                      outside;
    logic [NumLanes-1:0]       pneg;
    logic                      dneg;
    logic [31:0]               dmag;
    logic [NumLanes-1:0][32:0] ratio;
  } tc_t;

  // Late context (energy result and force sign)
  typedef struct packed {
    logic [31:0] energy;
    logic        fneg;
  } late_t;

  // Partial products of a 64x64 multiply
  typedef struct packed {
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } pp_t;

  function automatic pp_t mul_part(input logic [63:0] a, input logic [63:0] b);
    pp_t r;
    r.p00 = a[31:0] * b[31:0];
    r.p01 = a[31:0] * b[63:32];
    r.p10 = a[63:32] * b[31:0];
    r.p11 = a[63:32] * b[63:32];
    return r;
  endfunction

  // (a*b) >> 32, saturated to 64 bits
  function automatic logic [63:0] mul_comb(input pp_t p);
    logic [33:0] mid;
    logic [64:0] hi;
    mid = {2'b0, p.p00[63:32]} + {2'b0, p.p01[31:0]} + {2'b0, p.p10[31:0]};
    hi  = {1'b0, p.p11} + {33'b0, p.p01[63:32]} + {33'b0, p.p10[63:32]}
        + {63'b0, mid[33:32]};
    if (hi[64:32] != 33'd0) return '1;
    return {hi[31:0], mid[31:0]};
  endfunction

  function automatic logic [63:0] sat_mul12(input logic [63:0] x);
    logic [67:0] m;
    m = {1'b0, x, 3'b0} + {2'b0, x, 2'b0};
    return (m[67:64] != 4'd0) ? '1 : m[63:0];
  endfunction

  function automatic logic [63:0] sat_mul6(input logic [63:0] x);
    logic [67:0] m;
    m = {2'b0, x, 2'b0} + {3'b0, x, 1'b0};
    return (m[67:64] != 4'd0) ? '1 : m[63:0];
  endfunction

  // Magnitude and sign to saturated two's complement
  function automatic logic [31:0] to_s32(input logic [65:0] mag, input logic neg);
    logic [65:0] m;
    if (neg) begin
      m = (mag > 66'h80000000) ? 66'h80000000 : mag;
      return 32'd0 - m[31:0];
    end
    m = (mag > 66'h7FFFFFFF) ? 66'h7FFFFFFF : mag;
    return m[31:0];
  endfunction

  // One digit of the square root
  function automatic sqp_t sqrt_digit(input sqp_t s);
    sqp_t        r;
    logic [34:0] remsh;
    logic [34:0] trial;
    r     = s;
    remsh = {s.rem[32:0], s.v[63:62]};
    trial = {1'b0, s.root, 2'b01};
    if (remsh >= trial) begin
      r.rem  = remsh - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = remsh;
      r.root = {s.root[30:0], 1'b0};
    end
    r.v = {s.v[61:0], 2'b00};
    return r;
  endfunction

endpackage

/* sv/wca_boundary_force.sv */
// WCA wall force of a spherical confinement: fully pipelined datapath.
//
// Usage:
//   in_* is a valid/ready channel carrying one particle position per beat
//   (signed Q16.16). out_* is a valid/ready channel carrying one result
//   beat per position: force vector, energy and the outside flag.
//   cfg_* writes one register per cycle with cfg_we; write it only while
//   the pipeline holds no items.
// Throughput: one beat per cycle unless the output stalls. The depth
//   is set by the square root (16 stages, two root bits each), the
//   reciprocal divider (64 stages, one quotient bit each) and the
//   split 64-bit multiplier chain.
// Reset (rst_n low, synchronous) clears every valid bit and loads the
//   register defaults; no clearing pass is needed.
// Stall: when out_valid is high and out_ready low, the whole pipeline
//   holds and in_ready drops; nothing is lost or repeated.
module wca_boundary_force (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_force_x,
  output logic signed [31:0] out_force_y,
  output logic signed [31:0] out_force_z,
  output logic signed [31:0] out_energy,
  output logic               out_outside,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_wdata
);

  localparam int NL = wbf_pkg::NumLanes;
  localparam int NS = wbf_pkg::NumStages;

  // Configuration registers
  logic [1:0]  dims_r;
  logic [30:0] conf_r, cut_r, c6_r, c12_r, eshift_r, fcap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r   <= wbf_pkg::RstDims;
      conf_r   <= wbf_pkg::RstConfRadius;
      cut_r    <= wbf_pkg::RstCutRadius;
      c6_r     <= wbf_pkg::RstCoefSix;
      c12_r    <= wbf_pkg::RstCoefTwelve;
      eshift_r <= wbf_pkg::RstEnergyShift;
      fcap_r   <= wbf_pkg::RstForceCap;
    end else if (cfg_we) begin
      unique case (wbf_pkg::reg_idx_t'(cfg_index))
        wbf_pkg::REG_DIMS:         dims_r   <= cfg_wdata[1:0];
        wbf_pkg::REG_CONF_RADIUS:  conf_r   <= cfg_wdata;
        wbf_pkg::REG_CUT_RADIUS:   cut_r    <= cfg_wdata;
        wbf_pkg::REG_COEF_SIX:     c6_r     <= cfg_wdata;
        wbf_pkg::REG_COEF_TWELVE:  c12_r    <= cfg_wdata;
        wbf_pkg::REG_ENERGY_SHIFT: eshift_r <= cfg_wdata;
        wbf_pkg::REG_FORCE_CAP:    fcap_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless the output beat is stuck
  logic en, acc;
  logic out_valid_r;
  logic [NS-1:0] vld_r;

  assign en       = ~out_valid_r | out_ready;
  assign in_ready = en;
  assign acc      = in_valid & en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NS-2:0], acc};
      out_valid_r <= vld_r[NS-1];
    end
  end

  // Stage 1: magnitudes and signs, inactive lanes forced to zero
  wbf_pkg::front_t    fr1_nxt, fr1_r;
  logic [NL-1:0][31:0] pos_in;
  logic [1:0]          ndims;

  assign pos_in = {in_pos_z, in_pos_y, in_pos_x};
  assign ndims  = (dims_r == 2'd2) ? 2'd2 : 2'(wbf_pkg::MaxDims);

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      if (i < int'(ndims)) begin
        fr1_nxt.pneg[i] = pos_in[i][31];
        fr1_nxt.pmag[i] = pos_in[i][31] ? (32'd0 - pos_in[i]) : pos_in[i];
      end else begin
        fr1_nxt.pneg[i] = 1'b0;
        fr1_nxt.pmag[i] = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) fr1_r <= fr1_nxt;
  end

  // Stage 2: squares
  wbf_pkg::front_t     fr2_r;
  logic [NL-1:0][63:0] sq2_r;
  logic [61:0]         conf2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      fr2_r   <= fr1_r;
      conf2_r <= conf_r * conf_r;
      for (int i = 0; i < NL; i++) sq2_r[i] <= fr1_r.pmag[i] * fr1_r.pmag[i];
    end
  end

  // Stage 3: squared radius and inside test
  wbf_pkg::front_t fr3_r;
  logic [63:0]     r2_nxt, r2_r;
  logic            out3_r;

  always_comb begin
    r2_nxt = '0;
    for (int i = 0; i < NL; i++) r2_nxt = r2_nxt + sq2_r[i];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fr3_r  <= fr2_r;
      r2_r   <= r2_nxt;
      out3_r <= r2_nxt > {2'b0, conf2_r};
    end
  end

  // Square root pipeline, two digits per stage
  wbf_pkg::sqp_t sq_in  [wbf_pkg::SqrtStages];
  wbf_pkg::sqp_t sq_nxt [wbf_pkg::SqrtStages];
  wbf_pkg::sqp_t sq_r   [wbf_pkg::SqrtStages];

  assign sq_in[0] = '{v: r2_r, rem: '0, root: '0, outside: out3_r, fr: fr3_r};

  for (genvar k = 0; k < wbf_pkg::SqrtStages; k++) begin : g_sqrt
    if (k > 0) begin : g_link
      assign sq_in[k] = sq_r[k-1];
    end
    assign sq_nxt[k] = wbf_pkg::sqrt_digit(wbf_pkg::sqrt_digit(sq_in[k]));
    always_ff @(posedge clk) begin
      if (en) sq_r[k] <= sq_nxt[k];
    end
  end

  // D1: gap to the wall and first ratio digit
  wbf_pkg::sqp_t sq_last;
  wbf_pkg::dv_t  dv1_nxt, dv1_r, dv2_nxt, dv2_r;
  logic [31:0]   sum_rc;
  logic [31:0]   rmag;

  assign sq_last = sq_r[wbf_pkg::SqrtStages-1];
  assign rmag    = sq_last.root;
  assign sum_rc  = {1'b0, conf_r} + {1'b0, cut_r};

  always_comb begin
    dv1_nxt         = '0;
    dv1_nxt.outside = sq_last.outside;
    dv1_nxt.pneg    = sq_last.fr.pneg;
    dv1_nxt.rmag    = rmag;
    dv1_nxt.dneg    = rmag > sum_rc;
    dv1_nxt.dmag    = dv1_nxt.dneg ? (rmag - sum_rc) : (sum_rc - rmag);
    // zero gap counts as one LSB toward the inside
    if (dv1_nxt.dmag == 32'd0) begin
      dv1_nxt.dmag = 32'd1;
      dv1_nxt.dneg = 1'b0;
    end
    for (int i = 0; i < NL; i++) begin
      if (sq_last.fr.pmag[i] >= rmag) begin
        dv1_nxt.lq[i]   = 33'd1;
        dv1_nxt.lrem[i] = sq_last.fr.pmag[i] - rmag;
      end else begin
        dv1_nxt.lq[i]   = 33'd0;
        dv1_nxt.lrem[i] = sq_last.fr.pmag[i];
      end
    end
  end

  // D2: squared gap, divider seeded with the remainder after the top bit
  always_comb begin
    dv2_nxt      = dv1_r;
    dv2_nxt.d2   = dv1_r.dmag * dv1_r.dmag;
    dv2_nxt.rrem = 64'd1;
    dv2_nxt.rq   = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv1_r <= dv1_nxt;
      dv2_r <= dv2_nxt;
    end
  end

  // Reciprocal divider with the ratio lanes riding in its first stages
  wbf_pkg::dv_t dv_in  [wbf_pkg::RinvStages];
  wbf_pkg::dv_t dv_nxt [wbf_pkg::RinvStages];
  wbf_pkg::dv_t dv_r   [wbf_pkg::RinvStages];

  assign dv_in[0] = dv2_r;

  for (genvar k = 0; k < wbf_pkg::RinvStages; k++) begin : g_div
    if (k > 0) begin : g_link
      assign dv_in[k] = dv_r[k-1];
    end
    always_comb begin
      logic [64:0] rs;
      logic        ge;
      logic [32:0] ls;
      logic        lge;
      dv_nxt[k] = dv_in[k];
      rs        = {dv_in[k].rrem, 1'b0};
      ge        = rs >= {1'b0, dv_in[k].d2};
      dv_nxt[k].rrem = ge ? 64'(rs - {1'b0, dv_in[k].d2}) : rs[63:0];
      dv_nxt[k].rq   = {dv_in[k].rq[62:0], ge};
      if (k < wbf_pkg::RatioSteps) begin
        for (int i = 0; i < NL; i++) begin
          ls  = {dv_in[k].lrem[i], 1'b0};
          lge = ls >= {1'b0, dv_in[k].rmag};
          dv_nxt[k].lrem[i] = lge ? 32'(ls - {1'b0, dv_in[k].rmag}) : ls[31:0];
          dv_nxt[k].lq[i]   = {dv_in[k].lq[i][31:0], lge};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) dv_r[k] <= dv_nxt[k];
    end
  end

  // Tail context line
  wbf_pkg::dv_t dv_last;
  wbf_pkg::tc_t tc_in;
  wbf_pkg::tc_t tc_r [wbf_pkg::TailStages];

  assign dv_last = dv_r[wbf_pkg::RinvStages-1];
  assign tc_in   = '{outside: dv_last.outside, pneg: dv_last.pneg, dneg: dv_last.dneg,
                     dmag: dv_last.dmag, ratio: dv_last.lq};

  always_ff @(posedge clk) begin
    if (en) begin
      tc_r[0] <= tc_in;
      for (int k = 1; k < wbf_pkg::TailStages; k++) tc_r[k] <= tc_r[k-1];
    end
  end

  // Power chain: x = u*u, r6 = x*u, then b, a, e6, then e12, f12, f6
  wbf_pkg::pp_t ppx_r, ppy_r, ppb_r, ppa_r, ppe6_r, ppe12_r, ppf12_r, ppf6_r;
  logic [63:0]  u1_r, u2_r, u3_r, u4_r, x_r, r6_r, r6z_r, r6w_r;
  logic [63:0]  b_r, a_r, e6z_r, e6w1_r, e6w2_r, e6e1_r;
  logic [63:0]  e12_r, f12r_r, f6r_r;
  logic [63:0]  c6s, c12s;

  assign c6s  = {17'b0, c6_r, 16'b0};
  assign c12s = {17'b0, c12_r, 16'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      // X1, X2
      ppx_r   <= wbf_pkg::mul_part(dv_last.rq, dv_last.rq);
      u1_r    <= dv_last.rq;
      x_r     <= wbf_pkg::mul_comb(ppx_r);
      u2_r    <= u1_r;
      // Y1, Y2
      ppy_r   <= wbf_pkg::mul_part(x_r, u2_r);
      u3_r    <= u2_r;
      r6_r    <= wbf_pkg::mul_comb(ppy_r);
      u4_r    <= u3_r;
      // Z1, Z2
      ppb_r   <= wbf_pkg::mul_part(r6_r, u4_r);
      ppa_r   <= wbf_pkg::mul_part(c12s, r6_r);
      ppe6_r  <= wbf_pkg::mul_part(c6s, r6_r);
      r6z_r   <= r6_r;
      b_r     <= wbf_pkg::mul_comb(ppb_r);
      a_r     <= wbf_pkg::mul_comb(ppa_r);
      e6z_r   <= wbf_pkg::mul_comb(ppe6_r);
      r6w_r   <= r6z_r;
      // W1, W2
      ppe12_r <= wbf_pkg::mul_part(a_r, r6w_r);
      ppf12_r <= wbf_pkg::mul_part(a_r, b_r);
      ppf6_r  <= wbf_pkg::mul_part(c6s, b_r);
      e6w1_r  <= e6z_r;
      e12_r   <= wbf_pkg::mul_comb(ppe12_r);
      f12r_r  <= wbf_pkg::mul_comb(ppf12_r);
      f6r_r   <= wbf_pkg::mul_comb(ppf6_r);
      e6w2_r  <= e6w1_r;
    end
  end

  // E1: shifted energy sum, scaled force terms
  logic [64:0] psum;
  logic [63:0] p_r, f12_r, f6_r;

  assign psum = {1'b0, e12_r} + {18'b0, eshift_r, 16'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= psum[64] ? '1 : psum[63:0];
      f12_r  <= wbf_pkg::sat_mul12(f12r_r);
      f6_r   <= wbf_pkg::sat_mul6(f6r_r);
      e6e1_r <= e6w2_r;
    end
  end

  // E2: energy difference, force factor magnitude and sign
  logic [63:0] em_r, fd_r;
  logic        epos_r, fneg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      epos_r <= p_r >= e6e1_r;
      em_r   <= (p_r >= e6e1_r) ? (p_r - e6e1_r) : (e6e1_r - p_r);
      fneg_r <= f12_r < f6_r;
      fd_r   <= (f12_r >= f6_r) ? (f12_r - f6_r) : (f6_r - f12_r);
    end
  end

  // E3: energy to Q16.16 (floor), clamp force factor
  wbf_pkg::late_t lt_nxt;
  wbf_pkg::late_t lt_r [5];
  logic [63:0]    capq, fmag_r;
  logic [65:0]    emag;

  assign capq = {17'b0, fcap_r, 16'b0};
  assign emag = {18'b0, em_r[63:16]} + {65'b0, ~epos_r & (em_r[15:0] != 16'd0)};
  assign lt_nxt = '{energy: wbf_pkg::to_s32(emag, ~epos_r), fneg: fneg_r};

  always_ff @(posedge clk) begin
    if (en) begin
      fmag_r  <= (fd_r > capq) ? capq : fd_r;
      lt_r[0] <= lt_nxt;
      for (int k = 1; k < 5; k++) lt_r[k] <= lt_r[k-1];
    end
  end

  // T1, T2: t = fmag * dmag >> 32
  logic [63:0] tlo_r, thi_r, t_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tlo_r <= fmag_r[31:0] * tc_r[wbf_pkg::TcE3].dmag;
      thi_r <= fmag_r[63:32] * tc_r[wbf_pkg::TcE3].dmag;
      t_r   <= thi_r + {32'b0, tlo_r[63:32]};
    end
  end

  // F1, F2: per lane t * ratio >> 32
  logic [NL-1:0][64:0] plo_r, phi_r;
  logic [NL-1:0][65:0] fm_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NL; i++) begin
        plo_r[i] <= t_r[31:0] * tc_r[wbf_pkg::TcT2].ratio[i];
        phi_r[i] <= t_r[63:32] * tc_r[wbf_pkg::TcT2].ratio[i];
        fm_r[i]  <= {1'b0, phi_r[i]} + {34'b0, plo_r[i][63:32]};
      end
    end
  end

  // Output register
  logic [NL-1:0][31:0] force_nxt, force_r;
  logic [31:0]         energy_r;
  logic                outside_r;
  wbf_pkg::tc_t        tc_out;

  assign tc_out = tc_r[wbf_pkg::TcF2];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      if (!tc_out.outside || fm_r[i] == 66'd0) force_nxt[i] = 32'd0;
      else force_nxt[i] = wbf_pkg::to_s32(fm_r[i],
                            ~(lt_r[4].fneg ^ tc_out.dneg ^ tc_out.pneg[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      force_r   <= force_nxt;
      energy_r  <= tc_out.outside ? lt_r[4].energy : 32'd0;
      outside_r <= tc_out.outside;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_force_x = force_r[0];
  assign out_force_y = force_r[1];
  assign out_force_z = force_r[2];
  assign out_energy  = energy_r;
  assign out_outside = outside_r;

endmodule

/* tb/sv/wca_boundary_force_tb.sv */
// Self-checking testbench for the WCA boundary force pipeline.
module wca_boundary_force_tb;

  localparam logic [2:0] CfgNoReg = 3'd7;     // index past the register list
  localparam logic [30:0] Max31 = 31'h7FFFFFFF;
  localparam int PipeLatency = 101;

  typedef struct {
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] fz;
    logic [31:0] en;
    logic        outside;
  } wall_beat_t;

  // Scoreboard: register copy, force/energy predictor, queue of expected beats
  class wall_force_sb;
    logic [1:0]  dims;
    logic [30:0] conf_r, cut_r, c6, c12, eshift, fcap;
    wall_beat_t  pending[$];
    int          errors;

    function void reset_regs();
      dims = wbf_pkg::RstDims; conf_r = wbf_pkg::RstConfRadius;
      cut_r = wbf_pkg::RstCutRadius;
      c6 = wbf_pkg::RstCoefSix; c12 = wbf_pkg::RstCoefTwelve;
      eshift = wbf_pkg::RstEnergyShift;
      fcap = wbf_pkg::RstForceCap;
    endfunction

    function void write_reg(logic [2:0] idx, logic [30:0] d);
      case (idx)
        wbf_pkg::REG_DIMS:         dims = d[1:0];
        wbf_pkg::REG_CONF_RADIUS:  conf_r = d;
        wbf_pkg::REG_CUT_RADIUS:   cut_r = d;
        wbf_pkg::REG_COEF_SIX:     c6 = d;
        wbf_pkg::REG_COEF_TWELVE:  c12 = d;
        wbf_pkg::REG_ENERGY_SHIFT: eshift = d;
        wbf_pkg::REG_FORCE_CAP:    fcap = d;
        default: ;
      endcase
    endfunction

    // (a*b) >> 32, saturated to 64 bits
    function logic [63:0] mulq(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return (p[127:96] != 0) ? '1 : p[95:32];
    endfunction

    function logic [63:0] sat_k(logic [63:0] x, logic [3:0] k);
      logic [67:0] m;
      m = {4'd0, x} * {64'd0, k};
      return (m[67:64] != 0) ? '1 : m[63:0];
    endfunction

    function logic [63:0] root64(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function logic [31:0] sat32(logic [63:0] mag, bit neg);
      logic [63:0] m;
      if (neg) begin
        m = (mag > 64'h80000000) ? 64'h80000000 : mag;
        return 32'(64'h100000000 - m);
      end
      m = (mag > 64'h7FFFFFFF) ? 64'h7FFFFFFF : mag;
      return m[31:0];
    endfunction

    function wall_beat_t wall_force(logic [31:0] pos[3]);
      wall_beat_t  r;
      logic [63:0] pmag[3];
      bit          pneg[3];
      int          n;
      logic [63:0] r2, conf2, rmag, sum, dmag, d2, rinv, r6, b, a;
      logic [63:0] e12, e6, p, f12, f6, fmag, capq, t, m, ratio, fm, ones;
      bit          dneg, fneg;
      logic [31:0] fo[3];
      ones = '1;
      r = '{0, 0, 0, 0, 0};
      fo = '{0, 0, 0};
      for (int i = 0; i < 3; i++) begin
        pneg[i] = pos[i][31];
        pmag[i] = pneg[i] ? 64'h100000000 - {32'd0, pos[i]} : {32'd0, pos[i]};
      end
      n = (dims == 2) ? 2 : wbf_pkg::MaxDims;
      r2 = 0;
      for (int i = 0; i < n; i++) r2 = r2 + pmag[i] * pmag[i];
      conf2 = {33'd0, conf_r} * {33'd0, conf_r};
      if (r2 <= conf2) return r;

      rmag = root64(r2);
      sum = {33'd0, conf_r} + {33'd0, cut_r};
      if (sum >= rmag) begin
        dmag = sum - rmag; dneg = 0;
      end else begin
        dmag = rmag - sum; dneg = 1;
      end
      // zero gap is taken as one LSB toward the inside
      if (dmag == 0) begin
        dmag = 1; dneg = 0;
      end
      d2 = dmag * dmag;
      if (d2 == 1) begin
        rinv = ones;
      end else begin
        rinv = ones / d2;
        if (ones % d2 == d2 - 1) rinv = rinv + 1;
      end
      r6 = mulq(mulq(rinv, rinv), rinv);
      b = mulq(r6, rinv);
      a = mulq({17'd0, c12, 16'd0}, r6);

      // energy, floored to Q16.16
      e12 = mulq(a, r6);
      e6 = mulq({17'd0, c6, 16'd0}, r6);
      p = e12 + {17'd0, eshift, 16'd0};
      if (p < e12) p = ones;
      if (p >= e6) begin
        r.en = sat32((p - e6) >> 16, 0);
      end else begin
        m = e6 - p;
        r.en = sat32((m >> 16) + ((m[15:0] != 0) ? 64'd1 : 64'd0), 1);
      end

      // force factor, clamped
      f12 = sat_k(mulq(a, b), 4'd12);
      f6 = sat_k(mulq({17'd0, c6, 16'd0}, b), 4'd6);
      if (f12 >= f6) begin
        fmag = f12 - f6; fneg = 0;
      end else begin
        fmag = f6 - f12; fneg = 1;
      end
      capq = {17'd0, fcap, 16'd0};
      if (fmag > capq) fmag = capq;
      t = mulq(fmag, dmag);
      for (int i = 0; i < n; i++) begin
        ratio = (pmag[i] << 32) / rmag;
        fm = mulq(t, ratio);
        fo[i] = (fm == 0) ? 32'd0 : sat32(fm, !(fneg ^ dneg ^ pneg[i]));
      end
      r.fx = fo[0]; r.fy = fo[1]; r.fz = fo[2];
      r.outside = 1;
      return r;
    endfunction

    function void note_input(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      logic [31:0] pos[3];
      pos = '{x, y, z};
      pending.push_back(wall_force(pos));
    endfunction

    function void report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endfunction

    function void check_result(wall_beat_t got);
      wall_beat_t w;
      if (pending.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      w = pending.pop_front();
      if (got.fx !== w.fx) report($sformatf("force_x %h want %h", got.fx, w.fx));
      if (got.fy !== w.fy) report($sformatf("force_y %h want %h", got.fy, w.fy));
      if (got.fz !== w.fz) report($sformatf("force_z %h want %h", got.fz, w.fz));
      if (got.en !== w.en) report($sformatf("energy %h want %h", got.en, w.en));
      if (got.outside !== w.outside)
        report($sformatf("outside %b want %b", got.outside, w.outside));
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, out_outside;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic signed [31:0] out_force_x, out_force_y, out_force_z, out_energy;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [30:0] cfg_wdata;

  wall_force_sb sb;
  int ready_mode;
  int stall_left;

  wca_boundary_force dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Beat monitor, register tracking and receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      sb.reset_regs();
    end else begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (in_valid && in_ready) sb.note_input(in_pos_x, in_pos_y, in_pos_z);
      if (out_valid && out_ready)
        sb.check_result('{out_force_x, out_force_y, out_force_z, out_energy, out_outside});
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom % 4) != 0;
      default: begin
        if (stall_left > 0) begin
          stall_left <= stall_left - 1;
          out_ready <= 1'b0;
        end else if ($urandom % 16 == 0) begin
          stall_left <= $urandom_range(1, 25);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // One input beat; returns after acceptance
  task automatic send_pos(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_valid <= 1'b1;
    in_pos_x <= x; in_pos_y <= y; in_pos_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Wait one edge so the last accepted beat is queued, then until all are out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Drain, let the pipe settle, then load a full register set
  task automatic load_regs(logic [1:0] dm, logic [30:0] cr, logic [30:0] ct,
                           logic [30:0] s6, logic [30:0] s12, logic [30:0] es,
                           logic [30:0] fc);
    logic [30:0] vals[7];
    drain();
    repeat (PipeLatency + 10) @(posedge clk);
    vals = '{{29'd0, dm}, cr, ct, s6, s12, es, fc};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1; cfg_index <= 3'(i); cfg_wdata <= vals[i];
      @(posedge clk);
    end
    // write past the list must be ignored
    cfg_we <= 1'b1; cfg_index <= CfgNoReg; cfg_wdata <= 31'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Position near the wall most of the time, plus wide noise and points near the origin
  task automatic random_pos(output logic [31:0] p[3]);
    longint tgt, lim, span;
    int ax, sel;
    sel = $urandom % 10;
    if (sel < 6) begin
      span = longint'(sb.cut_r) * 3 + 131072;
      if (sel == 0) tgt = sb.conf_r + $urandom_range(0, 2);
      else tgt = longint'(sb.conf_r) - sb.cut_r + ($urandom() % span);
      if (tgt > 64'sh7FFFFFFF) tgt = 64'sh7FFFFFFF;
      if (tgt < 0) tgt = 0;
      lim = tgt / 8 + 1;
      for (int i = 0; i < 3; i++) p[i] = 32'(longint'($urandom() % (2 * lim)) - lim);
      ax = $urandom_range(0, 2);
      p[ax] = ($urandom % 2) ? 32'(-tgt) : 32'(tgt);
    end else if (sel < 9) begin
      for (int i = 0; i < 3; i++) p[i] = $urandom;
    end else begin
      for (int i = 0; i < 3; i++) p[i] = 32'($signed($urandom_range(0, 8191)) - 4096);
    end
  endtask

  // Random beats in bursts with gaps; one pause to drain mid phase
  task automatic random_phase(int count);
    logic [31:0] p[3];
    int burst;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom % 3 == 0) idle_cycles($urandom_range(1, 8));
      end
      if (k == count / 2) drain();
      random_pos(p);
      send_pos(p[0], p[1], p[2]);
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] cr, cs;
    sb = new();
    sb.errors = 0;
    sb.reset_regs();
    ready_mode = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_pos_x <= 0; in_pos_y <= 0; in_pos_z <= 0;
    cfg_we <= 1'b0; cfg_index <= 0; cfg_wdata <= 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset registers
    cr = {1'b0, wbf_pkg::RstConfRadius};
    cs = cr + {1'b0, wbf_pkg::RstCutRadius};
    send_pos(0, 0, 0);
    send_pos(cr, 0, 0);                        // on the boundary
    send_pos(cr + 1, 0, 0);                    // just outside
    send_pos(cs, 0, 0);                        // zero gap
    send_pos(0, -cs, 0);
    send_pos(cs + 32'd327680, 0, 0);           // beyond radius plus cutoff
    send_pos(32'h80000000, 32'h80000000, 32'h80000000);
    send_pos(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_pos(32'h80000000, 0, 0);
    send_pos(0, 32'h7FFFFFFF, 0);
    send_pos(0, 0, cr + 20000);
    send_pos(cr >> 1, -cr, cr);
    send_pos(-(cr + 4000), 3000, -3000);
    random_phase(200);

    // Two dimensions: z ignored
    load_regs(2, 655360, 73562, 262144, 262144, 65536, 6553600);
    ready_mode = 1;
    send_pos(0, 0, 32'h7FFFFFFF);
    send_pos(cr + 1000, -5, 7);
    send_pos(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    random_phase(200);

    load_regs(0, 65536, 65536, 262144, 131072, 65536, 3276800);
    ready_mode = 2;
    random_phase(200);

    load_regs(1, 0, 0, 0, 0, 0, 0);
    ready_mode = 0;
    random_phase(200);

    load_regs(3, Max31, Max31, Max31, Max31, Max31, Max31);
    ready_mode = 2;
    random_phase(200);

    load_regs(3, 327680, 16384, 131072, 31'h40000000, 32768, Max31);
    ready_mode = 1;
    random_phase(200);

    load_regs(2, 31'h100000, 1000, Max31, 1, 0, 65536);
    ready_mode = 2;
    random_phase(200);

    load_regs(2'($urandom), 31'($urandom_range(0, 31'h1000000)),
              31'($urandom_range(0, 200000)), 31'($urandom), 31'($urandom),
              31'($urandom), 31'($urandom));
    ready_mode = 1;
    random_phase(200);

    // Wait out the pipeline
    drain();
    repeat (PipeLatency + 20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
